/* hdl/sync_crc_packet_deframer_top_macros.svh */
// Assertion helpers for the packet deframer
`ifndef SYNC_CRC_PACKET_DEFRAMER_TOP_MACROS_SVH
`define SYNC_CRC_PACKET_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTH
`define SCPD_ASSERT_IMPL(label, clk, rst_n, antecedent, consequent, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (antecedent) |-> (consequent)) else $error(msg);
`define SCPD_ASSERT_NEXT(label, clk, rst_n, antecedent, consequent, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (antecedent) |=> (consequent)) else $error(msg);
`else
`define SCPD_ASSERT_IMPL(label, clk, rst_n, antecedent, consequent, msg)
`define SCPD_ASSERT_NEXT(label, clk, rst_n, antecedent, consequent, msg)
`endif
`endif

/* hdl/scpd_pkg.sv */
`default_nettype none
package scpd_pkg;
    localparam int LENGTH_BITS = 32;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL = 32'hFFFFFFFF;
    localparam logic [31:0] SYNC_NTSC_RESET = 32'hE3537A1F;
    localparam logic [31:0] SYNC_PAL_RESET = 32'hD193A745;
    localparam logic [7:0] TYPE_AUDIO = 8'h24;
    localparam logic [7:0] TYPE_GOP = 8'h12;
    localparam logic [7:0] TYPE_IFRAME = 8'h10;
    localparam logic [3:0] CRC_SPAN = 4'd12;

    localparam logic [0:0] REG_SYNC_NTSC = 1'b0;
    localparam logic [0:0] REG_SYNC_PAL = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT, PH_HEADER, PH_TIME, PH_AVTYPE, PH_ASUB,
        PH_ADATA, PH_VTYPE, PH_GOPHDR, PH_VDATA, PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK, ST_SYNC_LOST, ST_SHORT, ST_AUDIO_OVERRUN, ST_GOP_SHORT, ST_GOP_OVERRUN
    } status_t;

    typedef struct packed {
        logic [63:0] timecode;
        logic        payload_last;
        logic [2:0]  status;
        logic        crc_ok;
        logic [31:0] packet_length;
        logic [7:0]  header_flags;
        logic [7:0]  frame_rate;
        logic        is_pal;
        logic        header_done;
        logic [3:0]  byte_role;
        logic [7:0]  byte_echo;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction
endpackage
`default_nettype wire

/* hdl/scpd_parser.sv */
`default_nettype none
module scpd_parser
    import scpd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  b,
    input  wire logic [31:0] sync_ntsc,
    input  wire logic [31:0] sync_pal,
    output result_t          res
);
    localparam logic [LENGTH_BITS-1:0] LEN_MASK = {LENGTH_BITS{1'b1}};

    logic [31:0] win_reg, win_next;
    logic [2:0]  fill_reg, fill_next;
    phase_t      ph_reg, ph_next;
    logic [3:0]  fc_reg, fc_next;
    logic [31:0] crc_reg, crc_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] rem_reg, rem_next;
    logic [47:0] cap_reg, cap_next;

    logic [32:0] o1, len33, cs33;
    logic [31:0] sw, cs;
    logic [3:0]  idx;

    always_comb begin
        win_next = win_reg; fill_next = fill_reg; ph_next = ph_reg; fc_next = fc_reg;
        crc_next = crc_reg; acc_next = acc_reg; len_next = len_reg; off_next = off_reg;
        rem_next = rem_reg; cap_next = cap_reg;
        res = '0;
        res.byte_echo = b;
        idx = fc_reg;
        o1 = {1'b0, off_reg} + 33'd1;
        len33 = {1'b0, len_reg};
        sw = cap_reg[47:16];
        cs = acc_reg[31:0];
        cs33 = o1 + {1'b0, cs};
        case (ph_reg)
            PH_HUNT: begin
                win_next = {win_reg[23:0], b};
                if (fill_reg < 3'd4) fill_next = fill_reg + 3'd1;
                if (fill_next >= 3'd4 && (win_next == sync_ntsc || win_next == sync_pal)) begin
                    crc_next = crc_byte(crc_byte(crc_byte(crc_byte(CRC_ALL,
                        win_next[31:24]), win_next[23:16]), win_next[15:8]), win_next[7:0]);
                    cap_next = {16'd0, win_next};
                    fc_next = 4'd4;
                    acc_next = '0;
                    ph_next = PH_HEADER;
                    res.byte_role = PH_HEADER;
                end
            end
            PH_HEADER: begin
                res.byte_role = PH_HEADER;
                if (idx < CRC_SPAN) crc_next = crc_byte(crc_reg, b);
                if (idx < 4'd6) cap_next = {cap_reg[39:0], b};
                if (idx == 4'd8 || idx == 4'd12) acc_next = {56'd0, b};
                else if (idx > 4'd8)
                    acc_next = acc_reg | ({56'd0, b} << {idx[1:0], 3'd0});
                if (idx == 4'd11) len_next = acc_next[31:0] & 32'(LEN_MASK);
                if (idx < 4'd15) fc_next = idx + 4'd1;
                else if (sw != sync_ntsc && sw != sync_pal) begin
                    res.status = ST_SYNC_LOST;
                    ph_next = PH_HUNT; win_next = '0; fill_next = '0; fc_next = '0;
                end else begin
                    res.header_done = 1'b1;
                    res.is_pal = (sw != sync_ntsc);
                    res.frame_rate = cap_reg[15:8];
                    res.header_flags = cap_reg[7:0];
                    res.packet_length = len_reg;
                    res.crc_ok = ((crc_reg ^ CRC_ALL) == acc_next[31:0]);
                    off_next = '0; fc_next = '0;
                    if (len_reg == 32'd0) begin
                        res.status = ST_SHORT;
                        ph_next = PH_HEADER; crc_next = CRC_ALL; cap_next = '0; acc_next = '0;
                    end else if (len_reg < 32'd8) begin
                        res.status = ST_SHORT; ph_next = PH_SKIP;
                    end else ph_next = PH_TIME;
                end
            end
            default: begin
                res.byte_role = PH_SKIP;
                case (ph_reg)
                    PH_TIME: begin
                        res.byte_role = PH_TIME;
                        if (idx[2:0] == 3'd0) acc_next = {56'd0, b};
                        else acc_next = acc_reg | ({56'd0, b} << {idx[2:0], 3'd0});
                        if (idx[2:0] == 3'd7) begin
                            res.timecode = acc_next; ph_next = PH_AVTYPE;
                        end else fc_next = {1'b0, idx[2:0] + 3'd1};
                    end
                    PH_AVTYPE, PH_VTYPE: begin
                        if (ph_reg == PH_AVTYPE && b == TYPE_AUDIO) begin
                            res.byte_role = PH_AVTYPE;
                            if (o1 + 33'd6 > len33) ph_next = PH_VTYPE;
                            else begin ph_next = PH_ASUB; fc_next = '0; end
                        end else begin
                            res.byte_role = PH_VTYPE;
                            if (b == TYPE_GOP) begin
                                if (o1 + 33'd5 > len33) begin
                                    res.status = ST_GOP_SHORT; ph_next = PH_SKIP;
                                end else begin ph_next = PH_GOPHDR; fc_next = '0; end
                            end else if (b == TYPE_IFRAME) begin
                                rem_next = (len33 > o1) ? 32'(len33 - o1) : 32'd0;
                                ph_next = PH_VDATA;
                            end else ph_next = PH_SKIP;
                        end
                    end
                    PH_ASUB, PH_GOPHDR: begin
                        logic [3:0] base;
                        base = (ph_reg == PH_ASUB) ? 4'd2 : 4'd1;
                        res.byte_role = ph_reg;
                        if (idx == base) acc_next = {56'd0, b};
                        else if (idx > base)
                            acc_next = acc_reg | ({56'd0, b} << {2'(idx - base), 3'd0});
                        cs = acc_next[31:0];
                        cs33 = o1 + {1'b0, cs};
                        if (idx >= base + 4'd3) begin
                            if (cs33 > len33) begin
                                res.status = (ph_reg == PH_ASUB) ? ST_AUDIO_OVERRUN
                                                                 : ST_GOP_OVERRUN;
                                ph_next = (ph_reg == PH_ASUB) ? PH_VTYPE : PH_SKIP;
                            end else if (cs == 32'd0)
                                ph_next = (ph_reg == PH_ASUB) ? PH_AVTYPE : PH_SKIP;
                            else begin
                                rem_next = cs;
                                ph_next = (ph_reg == PH_ASUB) ? PH_ADATA : PH_VDATA;
                            end
                        end else fc_next = idx + 4'd1;
                    end
                    PH_ADATA, PH_VDATA: begin
                        res.byte_role = ph_reg;
                        if (rem_reg != 32'd0) rem_next = rem_reg - 32'd1;
                        if (rem_next == 32'd0)
                            ph_next = (ph_reg == PH_ADATA) ? PH_AVTYPE : PH_SKIP;
                    end
                    default: ;
                endcase
                if (o1 >= len33) begin
                    res.payload_last = 1'b1;
                    off_next = '0;
                    ph_next = PH_HEADER; fc_next = '0; crc_next = CRC_ALL;
                    cap_next = '0; acc_next = '0;
                end else off_next = o1[31:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0; fill_reg <= '0; ph_reg <= PH_HUNT; fc_reg <= '0;
            crc_reg <= CRC_ALL; acc_reg <= '0; len_reg <= '0; off_reg <= '0;
            rem_reg <= '0; cap_reg <= '0;
        end else if (step) begin
            win_reg <= win_next; fill_reg <= fill_next; ph_reg <= ph_next;
            fc_reg <= fc_next; crc_reg <= crc_next; acc_reg <= acc_next;
            len_reg <= len_next; off_reg <= off_next; rem_reg <= rem_next;
            cap_reg <= cap_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/sync_crc_packet_deframer_top.sv */
`default_nettype none
// Sync-word packet deframer: one result per input byte, one byte per clock
// sustained. A byte accepted on s_ is classified by the parser in the same
// cycle and its result lands in a single output register, which may be
// reloaded while it drains, so throughput is one transfer per cycle unless
// m_tready stalls. Configuration writes are taken only while the block is idle.
`include "sync_crc_packet_deframer_top_macros.svh"
module sync_crc_packet_deframer_top
    import scpd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] stream_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] byte_echo, [11:8] byte_role, [12] header_done, [13] is_pal,
    // [21:14] frame_rate, [29:22] header_flags, [61:30] packet_length,
    // [62] crc_ok, [65:63] status, [129:66] timecode, [135:130] zero
    output logic [135:0]      m_tdata,
    output logic              m_tlast,   // payload_last
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    logic [31:0] ntsc_reg, pal_reg;
    logic        step, vld_reg;
    result_t     res, out_reg;

    assign s_tready = !vld_reg || m_tready;
    assign step = s_tvalid && s_tready;
    // hold off writes while a byte is offered or a result is still waiting
    assign cfg_ready = !vld_reg && !s_tvalid;

    scpd_parser u_parser (
        .aclk(aclk), .aresetn(aresetn), .step(step), .b(s_tdata),
        .sync_ntsc(ntsc_reg), .sync_pal(pal_reg), .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ntsc_reg <= SYNC_NTSC_RESET;
            pal_reg <= SYNC_PAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SYNC_NTSC: ntsc_reg <= cfg_data;
                REG_SYNC_PAL: pal_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= 1'b0;
        else if (s_tready) vld_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (step) out_reg <= res;
    end

    assign m_tvalid = vld_reg;
    assign m_tlast = out_reg.payload_last;
    assign m_tdata = {6'd0, out_reg.timecode, out_reg.status, out_reg.crc_ok,
                      out_reg.packet_length, out_reg.header_flags, out_reg.frame_rate,
                      out_reg.is_pal, out_reg.header_done, out_reg.byte_role,
                      out_reg.byte_echo};

    `SCPD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `SCPD_ASSERT_NEXT(a_load, aclk, aresetn, step, m_tvalid && m_tdata[7:0] == $past(s_tdata), "echo mismatch")
    `SCPD_ASSERT_IMPL(a_hdr, aclk, aresetn, m_tvalid && m_tdata[12], m_tdata[11:8] == 4'd1, "header_done off header")
endmodule
`default_nettype wire
